// ----- rtl/mh2s_pkg.sv -----
package mh2s_pkg;

	// Hash constants of the 32-bit MurmurHash2 scheme.
	localparam logic [31:0] MH_SEED = 32'h9747b28c;
	localparam logic [31:0] MH_MULT = 32'h5bd1e995;
	localparam int MH_ROT = 24;
	localparam int FIN_SHIFT_A = 13;
	localparam int FIN_SHIFT_B = 15;

	// Field widths.
	localparam int HASH_W = 32;
	localparam int SHARD_W = 16;
	localparam int LEN_W = 16;
	localparam int CNT_W = 3;
	localparam int DIV_CNT_W = $clog2(HASH_W);

	// Byte counts of a partial word.
	localparam logic [CNT_W-1:0] CNT_ONE = 3'd1;
	localparam logic [CNT_W-1:0] CNT_TWO = 3'd2;
	localparam logic [CNT_W-1:0] CNT_THREE = 3'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_HM,
		ST_TAIL,
		ST_FIN,
		ST_DIV,
		ST_EMIT
	} mh2s_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul_k1;
		logic mul_k2;
		logic mul_h;
		logic mul_tail;
		logic fin;
		logic div_step;
		logic emit;
	} mh2s_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_full;
		logic in_zero;
		logic in_last;
		logic last_q;
		logic div_last;
		logic out_free;
	} mh2s_sts_t;

	// Keeps the valid low bytes of a partial word.
	function automatic logic [HASH_W-1:0] tail_mask(input logic [CNT_W-1:0] cnt);
		logic [HASH_W-1:0] m;
		unique case (cnt)
			CNT_ONE: m = 32'h0000_00ff;
			CNT_TWO: m = 32'h0000_ffff;
			CNT_THREE: m = 32'h00ff_ffff;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// ----- rtl/mh2s_if.sv -----
// Key word channel.
interface mh2s_in_if;
	logic valid;
	logic ready;
	logic first_word;
	logic [15:0] key_length;
	logic [31:0] data_word;
	logic [2:0] byte_count;
	logic last_word;

	modport source (
		output valid, first_word, key_length, data_word, byte_count, last_word,
		input ready
	);
	modport sink (
		input valid, first_word, key_length, data_word, byte_count, last_word,
		output ready
	);
endinterface

// Result channel.
interface mh2s_out_if;
	logic valid;
	logic ready;
	logic [31:0] hash_value;
	logic [15:0] shard_index;

	modport source (
		output valid, hash_value, shard_index,
		input ready
	);
	modport sink (
		input valid, hash_value, shard_index,
		output ready
	);
endinterface

// ----- rtl/mh2s_ctrl.sv -----
module mh2s_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input mh2s_pkg::mh2s_sts_t sts,
	output mh2s_pkg::mh2s_cmd_t cmd
);
	import mh2s_pkg::*;

	mh2s_state_t state_q;
	mh2s_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					priority if (sts.in_full) state_d = ST_K1;
					else if (!sts.in_zero) state_d = ST_TAIL;
					else if (sts.in_last) state_d = ST_FIN;
					else state_d = ST_IDLE;
				end
			end
			ST_K1: state_d = ST_K2;
			ST_K2: state_d = ST_HM;
			ST_HM, ST_TAIL: state_d = sts.last_q ? ST_FIN : ST_IDLE;
			ST_FIN: state_d = ST_DIV;
			ST_DIV: state_d = sts.div_last ? ST_EMIT : ST_DIV;
			ST_EMIT: state_d = sts.out_free ? ST_IDLE : ST_EMIT;
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands decoded from the state, the input valid and the output slot.
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd = '0;
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.mul_k1 = (state_q == ST_K1);
		cmd.mul_k2 = (state_q == ST_K2);
		cmd.mul_h = (state_q == ST_HM);
		cmd.mul_tail = (state_q == ST_TAIL);
		cmd.fin = (state_q == ST_FIN);
		cmd.div_step = (state_q == ST_DIV);
		cmd.emit = (state_q == ST_EMIT) && sts.out_free;
	end

endmodule

// ----- rtl/mh2s_dp.sv -----
module mh2s_dp (
	input logic clk,
	input logic arst_n,
	input mh2s_pkg::mh2s_cmd_t cmd,
	output mh2s_pkg::mh2s_sts_t sts,
	input logic first_word,
	input logic [mh2s_pkg::LEN_W-1:0] key_length,
	input logic [mh2s_pkg::HASH_W-1:0] data_word,
	input logic [mh2s_pkg::CNT_W-1:0] byte_count,
	input logic last_word,
	input logic cfg_we,
	input logic [mh2s_pkg::SHARD_W-1:0] cfg_wdata,
	input logic out_ready,
	output logic out_valid,
	output logic [mh2s_pkg::HASH_W-1:0] hash_value,
	output logic [mh2s_pkg::SHARD_W-1:0] shard_index
);
	import mh2s_pkg::*;

	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] word_q;
	logic [CNT_W-1:0] cnt_q;
	logic last_q;
	logic [HASH_W-1:0] k_q;
	logic [HASH_W-1:0] fin_q;
	logic [HASH_W-1:0] dvd_q;
	logic [SHARD_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [SHARD_W-1:0] shard_count_q;
	logic out_valid_q;
	logic [HASH_W-1:0] out_hash_q;
	logic [SHARD_W-1:0] out_shard_q;

	logic [HASH_W-1:0] mul_op;
	logic [HASH_W-1:0] product;
	logic [HASH_W-1:0] fin_val;
	logic [SHARD_W:0] rem_sh;
	logic [SHARD_W:0] rem_sub;
	logic rem_ge;

	// Operand select for the shared multiplier; the other factor is fixed.
	always_comb begin
		priority if (cmd.mul_k1) mul_op = word_q;
		else if (cmd.mul_k2) mul_op = k_q ^ (k_q >> MH_ROT);
		else if (cmd.mul_h) mul_op = acc_q;
		else if (cmd.mul_tail) mul_op = acc_q ^ (word_q & tail_mask(cnt_q));
		else mul_op = acc_q ^ (acc_q >> FIN_SHIFT_A);
	end

	assign product = mul_op * MH_MULT;
	assign fin_val = product ^ (product >> FIN_SHIFT_B);

	// One restoring division step per cycle.
	assign rem_sh = {rem_q, dvd_q[HASH_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, shard_count_q});
	assign rem_sub = rem_sh - {1'b0, shard_count_q};

	// Control state and the running hash.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			shard_count_q <= SHARD_W'(1);
			out_valid_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				shard_count_q <= cfg_wdata;
			end
			if (cmd.load && first_word) begin
				acc_q <= MH_SEED ^ {{(HASH_W-LEN_W){1'b0}}, key_length};
			end else if (cmd.mul_h) begin
				acc_q <= product ^ k_q;
			end else if (cmd.mul_tail) begin
				acc_q <= product;
			end
			if (cmd.fin) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= data_word;
			cnt_q <= byte_count;
			last_q <= last_word;
		end
		if (cmd.mul_k1 || cmd.mul_k2) begin
			k_q <= product;
		end
		if (cmd.fin) begin
			fin_q <= fin_val;
			dvd_q <= fin_val;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			rem_q <= rem_ge ? rem_sub[SHARD_W-1:0] : rem_sh[SHARD_W-1:0];
		end
		if (cmd.emit) begin
			out_hash_q <= fin_q;
			out_shard_q <= (shard_count_q == '0) ? '0 : rem_q;
		end
	end

	// Status back to the controller.
	always_comb begin
		sts.in_full = byte_count[CNT_W-1];
		sts.in_zero = (byte_count == '0);
		sts.in_last = last_word;
		sts.last_q = last_q;
		sts.div_last = (div_cnt_q == DIV_CNT_W'(HASH_W-1));
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign hash_value = out_hash_q;
	assign shard_index = out_shard_q;

endmodule

// ----- rtl/murmurhash2_shard_select_core.sv -----
// MurmurHash2 shard selector.
// A key enters on the "in" channel as 32-bit little-endian words, one per
// transfer. The first word carries the key length and starts a new hash from
// the seed; the last word may hold 0 to 4 bytes and closes the key. For each
// key the "out" channel gives one transfer with the finalized 32-bit hash and
// the hash modulo the shard count written through cfg_we/cfg_wdata.
// One shared 32x32 multiplier sets the word rate. A full word passes through
// the transfer and three dependent multiplies, a partial word through the
// transfer and a tail multiply, and an empty word only through the transfer.
// A last word then goes through the finalizer, the bit-serial remainder unit
// and the output register load, which waits for a free output slot.
// A result waits in the output register while the receiver stalls, and words
// of the next key are still taken. If that key finishes before the slot frees,
// the block holds its final state and takes no new word until the slot frees.
// Reset clears the running hash to zero, the shard count to one and drops
// the output valid. Write the shard count only while no key is in flight.
module murmurhash2_shard_select_core (
	input logic clk,
	input logic arst_n,
	mh2s_in_if.sink in,
	mh2s_out_if.source out,
	input logic cfg_we,
	input logic [mh2s_pkg::SHARD_W-1:0] cfg_wdata
);
	import mh2s_pkg::*;

	mh2s_cmd_t cmd;
	mh2s_sts_t sts;

	// Sequencer.
	mh2s_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in.valid),
		.in_ready(in.ready),
		.sts(sts),
		.cmd(cmd)
	);

	// Hash and remainder datapath.
	mh2s_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.first_word(in.first_word),
		.key_length(in.key_length),
		.data_word(in.data_word),
		.byte_count(in.byte_count),
		.last_word(in.last_word),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_ready(out.ready),
		.out_valid(out.valid),
		.hash_value(out.hash_value),
		.shard_index(out.shard_index)
	);

endmodule

// ----- rtl/mh2s_checker.sv -----
module mh2s_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [2:0] in_byte_count,
	input logic in_last_word,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] out_hash_value,
	input logic [15:0] out_shard_index
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hash_value)
			&& $stable(out_shard_index))
		else $error("stalled result changed");

	// A word transfer never coincides with a result being produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared right after a word transfer");

	// A full word holds the input off for its K1, K2 and HM rounds.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_byte_count[2] |=> !in_ready ##1 !in_ready ##1 !in_ready)
		else $error("word taken while a full-word round was running");

	// The last word of a key blocks the input while the result is built.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last_word |=> !in_ready ##1 !in_ready)
		else $error("word taken while a key was finishing");

	// A remainder by a 16-bit count never reaches the all-ones value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_shard_index != 16'hffff)
		else $error("shard index out of range");

endmodule

bind murmurhash2_shard_select_core mh2s_checker u_mh2s_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in.valid),
	.in_ready(in.ready),
	.in_byte_count(in.byte_count),
	.in_last_word(in.last_word),
	.out_valid(out.valid),
	.out_ready(out.ready),
	.out_hash_value(out.hash_value),
	.out_shard_index(out.shard_index)
);

// ----- dv/murmurhash2_shard_select_scoreboard.sv -----
// Watches the key word and result channels of the shard selector, predicts
// each result from the accepted words and compares it with what comes out.
module murmurhash2_shard_select_scoreboard (
	input logic clk,
	input logic arst_n,
	mh2s_in_if key_words,
	mh2s_out_if hash_results,
	input logic cfg_we,
	input logic [mh2s_pkg::SHARD_W-1:0] cfg_wdata,
	output int fail_count,
	output int pending
);

	localparam logic [31:0] HASH_SEED = 32'h9747_b28c;
	localparam logic [31:0] HASH_MULT = 32'h5bd1_e995;
	localparam int WORD_SHIFT = 24;

	typedef struct packed {
		logic [31:0] hash_value;
		logic [15:0] shard_index;
	} shard_pick_t;

	shard_pick_t picks_due[$];
	logic [31:0] running_hash;
	logic [15:0] shard_count;

	// One multiply-shift round for a word with four valid bytes.
	function automatic logic [31:0] mix_full_word(input logic [31:0] h, input logic [31:0] k);
		logic [31:0] kk;
		kk = k * HASH_MULT;
		kk = kk ^ (kk >> WORD_SHIFT);
		kk = kk * HASH_MULT;
		return (h * HASH_MULT) ^ kk;
	endfunction

	// Final avalanche applied on the last word of a key.
	function automatic logic [31:0] avalanche(input logic [31:0] h);
		logic [31:0] f;
		f = h ^ (h >> 13);
		f = f * HASH_MULT;
		return f ^ (f >> 15);
	endfunction

	// Advances the running hash by one word and queues a result on the last one.
	task automatic absorb_word(input logic first, input logic [15:0] len,
			input logic [31:0] data, input logic [2:0] cnt, input logic last);
		logic [31:0] h;
		logic [31:0] idx;
		shard_pick_t pick;
		if (first)
			running_hash = HASH_SEED ^ {16'h0, len};
		h = running_hash;
		if (cnt >= 3'd4) begin
			h = mix_full_word(h, data);
		end else if (cnt != 3'd0) begin
			h = h ^ (data & ~(32'hffff_ffff << (8 * cnt)));
			h = h * HASH_MULT;
		end
		running_hash = h;
		if (last) begin
			pick.hash_value = avalanche(h);
			idx = (shard_count != 16'd0) ? pick.hash_value % {16'h0, shard_count} : 32'd0;
			pick.shard_index = idx[15:0];
			picks_due = {picks_due, pick};
		end
	endtask

	// Compares one result transfer against the oldest prediction.
	task automatic check_result(input logic [31:0] hash_got, input logic [15:0] shard_got);
		shard_pick_t want;
		if (picks_due.size() == 0) begin
			$error("unexpected result: hash_value %h shard_index %0d", hash_got, shard_got);
			fail_count++;
		end else begin
			want = picks_due.pop_front();
			if (hash_got !== want.hash_value) begin
				$error("hash_value mismatch: expected %h, actual %h", want.hash_value, hash_got);
				fail_count++;
			end
			if (shard_got !== want.shard_index) begin
				$error("shard_index mismatch: expected %0d, actual %0d",
					want.shard_index, shard_got);
				fail_count++;
			end
		end
	endtask

	// Sample every transfer and configuration write at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash = 32'h0;
			shard_count = 16'd1;
			picks_due.delete();
			fail_count = 0;
		end else begin
			if (cfg_we)
				shard_count = cfg_wdata;
			if (hash_results.valid && hash_results.ready)
				check_result(hash_results.hash_value, hash_results.shard_index);
			if (key_words.valid && key_words.ready)
				absorb_word(key_words.first_word, key_words.key_length, key_words.data_word,
					key_words.byte_count, key_words.last_word);
		end
		pending = picks_due.size();
	end

endmodule

// ----- dv/murmurhash2_shard_select_core_tb.sv -----
// Drives keys into the shard selector under several shard counts and
// flow-control patterns; the scoreboard does the checking.
module murmurhash2_shard_select_core_tb;

	import mh2s_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 5;
	localparam int ITEM_GOAL = 1650;
	localparam int PHASE_COUNT = 5;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [SHARD_W-1:0] cfg_wdata;
	int fail_count;
	int pending;
	int idle_pct;
	int stall_pct;
	int items_sent;
	logic hold_request;

	mh2s_in_if key_words();
	mh2s_out_if hash_results();

	murmurhash2_shard_select_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in(key_words),
		.out(hash_results),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	murmurhash2_shard_select_scoreboard hash_check (
		.clk(clk),
		.arst_n(arst_n),
		.key_words(key_words),
		.hash_results(hash_results),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #HALF_PERIOD clk = ~clk;

	// Offers one word, idling at random first, and returns once it is transferred.
	task automatic send_word(input logic first, input logic [15:0] len,
			input logic [31:0] data, input logic [2:0] cnt, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			key_words.valid <= 1'b0;
			key_words.data_word <= $urandom;
			@(negedge clk);
		end
		key_words.valid <= 1'b1;
		key_words.first_word <= first;
		key_words.key_length <= len;
		key_words.data_word <= data;
		key_words.byte_count <= cnt;
		key_words.last_word <= last;
		@(posedge clk);
		while (!key_words.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Sends a key of the given byte length and length field with random content.
	task automatic send_key(input int key_len, input logic [15:0] len_field);
		int words;
		int left;
		logic [2:0] cnt;
		words = (key_len + 3) / 4;
		if (words == 0)
			words = 1;
		left = key_len;
		for (int w = 0; w < words; w++) begin
			cnt = (left >= 4) ? 3'd4 : 3'(left);
			left -= int'(cnt);
			// Out-of-range counts on full words must behave like four.
			if (cnt == 3'd4 && $urandom_range(9) == 0)
				cnt = 3'($urandom_range(7, 5));
			send_word(w == 0, len_field, $urandom, cnt, w == words - 1);
		end
	endtask

	// Lets the block drain and settle, then writes the shard count.
	task automatic write_shard_count(input logic [SHARD_W-1:0] value);
		@(negedge clk);
		key_words.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Result receiver: random stalls, plus a long hold-off on request.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		hash_results.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hash_results.ready <= 1'b0;
				hold_left--;
			end else begin
				hash_results.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Ends the run when nothing has been transferred for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((key_words.valid && key_words.ready) ||
					(hash_results.valid && hash_results.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Reset, directed keys, then random phases over several shard counts.
	initial begin : stimulus
		int phase_budget;
		int phase_end;
		int key_len;
		logic [SHARD_W-1:0] shard_plan[PHASE_COUNT];
		int idle_plan[PHASE_COUNT];
		int stall_plan[PHASE_COUNT];

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		hold_request = 1'b0;
		key_words.valid = 1'b0;
		key_words.first_word = 1'b0;
		key_words.key_length = '0;
		key_words.data_word = '0;
		key_words.byte_count = '0;
		key_words.last_word = 1'b0;

		shard_plan = '{16'hffff, 16'd3, 16'd0, 16'($urandom_range(65534, 2)), 16'd1};
		idle_plan = '{0, 81, 0, 8, 0};
		stall_plan = '{0, 0, 81, 8, 0};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A word with no first word after reset continues from a zero hash.
		send_word(1'b0, 16'd0, 32'h1234_5678, 3'd4, 1'b1);
		// Zero-length key: one empty word that is both first and last.
		send_word(1'b1, 16'd0, 32'hffff_ffff, 3'd0, 1'b1);
		// Single-word keys, partial and full; the bytes above the count must be ignored.
		send_word(1'b1, 16'd1, 32'hffff_ffff, 3'd1, 1'b1);
		send_word(1'b1, 16'd2, 32'ha5a5_a5a5, 3'd2, 1'b1);
		send_word(1'b1, 16'd3, 32'hffff_ffff, 3'd3, 1'b1);
		send_word(1'b1, 16'd4, 32'hffff_ffff, 3'd4, 1'b1);
		send_word(1'b1, 16'd4, 32'h0000_0000, 3'd4, 1'b1);
		// Counts above four get a full round; maximum length in the seed.
		send_word(1'b1, 16'hffff, 32'hdead_beef, 3'd5, 1'b1);
		send_word(1'b1, 16'd8, 32'h0f1e_2d3c, 3'd6, 1'b0);
		send_word(1'b0, 16'd8, 32'hc3d2_e1f0, 3'd7, 1'b1);
		// A partial word in the middle of a key gets the tail mix and goes on.
		send_word(1'b1, 16'd6, 32'h89ab_cdef, 3'd2, 1'b0);
		send_word(1'b0, 16'd6, 32'h7654_3210, 3'd4, 1'b1);
		// Empty words inside a key add nothing.
		send_word(1'b1, 16'd4, 32'h5555_aaaa, 3'd0, 1'b0);
		send_word(1'b0, 16'd4, 32'haaaa_5555, 3'd4, 1'b0);
		send_word(1'b0, 16'd4, 32'h0123_4567, 3'd0, 1'b1);
		// Length that disagrees with the words sent.
		send_word(1'b1, 16'd0, 32'h00c0_ffee, 3'd3, 1'b1);
		// Continue without a first word from the unfinalized previous hash.
		send_word(1'b0, 16'h8000, 32'hfedc_ba98, 3'd1, 1'b1);
		send_word(1'b0, 16'h7fff, 32'h1357_9bdf, 3'd4, 1'b1);

		phase_budget = (ITEM_GOAL - items_sent) / PHASE_COUNT;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_shard_count(shard_plan[p]);
			idle_pct = idle_plan[p];
			stall_pct = stall_plan[p];
			// Fill the block against a receiver that holds off for a long time.
			if (p == 0)
				hold_request = 1'b1;
			phase_end = items_sent + phase_budget;
			while (items_sent < phase_end) begin
				if ($urandom_range(99) < 15) begin
					send_word(1'($urandom_range(1)), 16'($urandom), $urandom,
						3'($urandom_range(7)), 1'($urandom_range(1)));
				end else begin
					key_len = ($urandom_range(9) == 0) ? $urandom_range(300)
						: $urandom_range(24);
					send_key(key_len, ($urandom_range(9) == 0) ? 16'($urandom)
						: 16'(key_len));
				end
			end
		end

		@(negedge clk);
		key_words.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/mh2s_pkg.sv
rtl/mh2s_if.sv
rtl/mh2s_ctrl.sv
rtl/mh2s_dp.sv
rtl/murmurhash2_shard_select_core.sv
rtl/mh2s_checker.sv
dv/murmurhash2_shard_select_scoreboard.sv
dv/murmurhash2_shard_select_core_tb.sv
